>>> hdl/tls_pkg.sv
// Shared types, constants and helpers for the traffic light sequencer.
// No dependencies; used by tls_step and traffic_light_sequencer.
package tls_pkg;

  // Default width of the shared tick counter
  localparam int COUNT_WIDTH_DEF = 16;

  localparam int TIME_W   = 16;  // timing register width
  localparam int TOGGLE_W = 4;   // toggle count / limit width
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int CODE_W   = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RED_TICKS        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RED_YELLOW_TICKS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GREEN_TICKS      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_HALF_TICKS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_TOGGLES    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_YELLOW_TICKS     = 3'd5;

  // Register reset values
  localparam logic [TIME_W-1:0]   RED_TICKS_RST        = 16'd2000;
  localparam logic [TIME_W-1:0]   RED_YELLOW_TICKS_RST = 16'd1600;
  localparam logic [TIME_W-1:0]   GREEN_TICKS_RST      = 16'd2000;
  localparam logic [TIME_W-1:0]   BLINK_HALF_TICKS_RST = 16'd500;
  localparam logic [TOGGLE_W-1:0] BLINK_TOGGLES_RST    = 4'd9;
  localparam logic [TIME_W-1:0]   YELLOW_TICKS_RST     = 16'd1800;

  // Phase codes as seen on phase_code
  localparam logic [CODE_W-1:0] CODE_RED         = 3'd0;
  localparam logic [CODE_W-1:0] CODE_RED_YELLOW  = 3'd1;
  localparam logic [CODE_W-1:0] CODE_GREEN       = 3'd2;
  localparam logic [CODE_W-1:0] CODE_GREEN_BLINK = 3'd3;
  localparam logic [CODE_W-1:0] CODE_YELLOW      = 3'd4;
  localparam logic [CODE_W-1:0] CODE_NIGHT       = 3'd5;

  typedef enum logic [5:0] {
    PH_RED         = 6'b000001,
    PH_RED_YELLOW  = 6'b000010,
    PH_GREEN       = 6'b000100,
    PH_GREEN_BLINK = 6'b001000,
    PH_YELLOW      = 6'b010000,
    PH_NIGHT       = 6'b100000
  } phase_t;

  typedef struct packed {
    logic red;
    logic yellow;
    logic green;
  } lamps_t;

  typedef struct packed {
    logic [TIME_W-1:0]   red_ticks;
    logic [TIME_W-1:0]   red_yellow_ticks;
    logic [TIME_W-1:0]   green_ticks;
    logic [TIME_W-1:0]   blink_half_ticks;
    logic [TOGGLE_W-1:0] blink_toggles;
    logic [TIME_W-1:0]   yellow_ticks;
  } cfg_t;

  // Sequencer state, less the tick counter (its width is a parameter)
  typedef struct packed {
    phase_t              phase;
    logic [TOGGLE_W-1:0] toggle_count;
    lamps_t              lamps;
  } seq_state_t;

  function automatic logic [CODE_W-1:0] phase_code_f(input phase_t ph);
    logic [CODE_W-1:0] code;
    case (ph)
      PH_RED:         code = CODE_RED;
      PH_RED_YELLOW:  code = CODE_RED_YELLOW;
      PH_GREEN:       code = CODE_GREEN;
      PH_GREEN_BLINK: code = CODE_GREEN_BLINK;
      PH_YELLOW:      code = CODE_YELLOW;
      PH_NIGHT:       code = CODE_NIGHT;
      default:        code = CODE_RED;
    endcase
    return code;
  endfunction

endpackage

>>> hdl/tls_step.sv
// Next-state logic for one tick of the traffic light sequencer.
// Depends on tls_pkg.
module tls_step #(
  parameter int COUNT_WIDTH = tls_pkg::COUNT_WIDTH_DEF
) (
  input  tls_pkg::cfg_t       cfg,
  input  tls_pkg::seq_state_t st,
  input  logic [COUNT_WIDTH-1:0] tick_count,
  input  logic                night_mode,
  output tls_pkg::seq_state_t st_next,
  output logic [COUNT_WIDTH-1:0] tick_count_next
);
  import tls_pkg::*;

  // Compare width covers both the counter and the 16-bit limits
  localparam int CMP_W = (COUNT_WIDTH > TIME_W) ? COUNT_WIDTH : TIME_W;

  logic [COUNT_WIDTH-1:0] tick_inc;
  logic [CMP_W-1:0]       tick_ext;
  logic [TIME_W-1:0]      limit;
  logic                   reached;
  logic                   half_reached;

  // Saturating increment
  assign tick_inc = (&tick_count) ? tick_count : tick_count + 1'b1;
  assign tick_ext = CMP_W'(tick_inc);

  always_comb begin
    case (st.phase)
      PH_RED:        limit = cfg.red_ticks;
      PH_RED_YELLOW: limit = cfg.red_yellow_ticks;
      PH_GREEN:      limit = cfg.green_ticks;
      PH_YELLOW:     limit = cfg.yellow_ticks;
      default:       limit = cfg.blink_half_ticks;
    endcase
  end

  assign reached      = tick_ext >= CMP_W'(limit);
  assign half_reached = tick_ext >= CMP_W'(cfg.blink_half_ticks);

  always_comb begin
    st_next         = st;
    tick_count_next = tick_inc;
    case (st.phase)
      PH_RED: begin
        if (night_mode) begin
          st_next.lamps.red   = 1'b0;
          st_next.lamps.green = 1'b0;
          st_next.phase       = PH_NIGHT;
        end else begin
          st_next.lamps = '{red: 1'b1, yellow: 1'b0, green: 1'b0};
          if (reached) begin
            tick_count_next = '0;
            st_next.phase   = PH_RED_YELLOW;
          end
        end
      end
      PH_RED_YELLOW: begin
        st_next.lamps = '{red: 1'b1, yellow: 1'b1, green: 1'b0};
        if (reached) begin
          tick_count_next = '0;
          st_next.phase   = PH_GREEN;
        end
      end
      PH_GREEN: begin
        st_next.lamps = '{red: 1'b0, yellow: 1'b0, green: 1'b1};
        if (reached) begin
          tick_count_next = '0;
          st_next.phase   = PH_GREEN_BLINK;
        end
      end
      PH_GREEN_BLINK: begin
        // toggle limit is checked before timing; counter not cleared on exit
        if (st.toggle_count >= cfg.blink_toggles) begin
          st_next.toggle_count = '0;
          st_next.phase        = PH_YELLOW;
        end else if (half_reached) begin
          tick_count_next      = '0;
          st_next.toggle_count = st.toggle_count + 1'b1;
          st_next.lamps.green  = ~st.lamps.green;
        end
      end
      PH_YELLOW: begin
        st_next.lamps = '{red: 1'b0, yellow: 1'b1, green: 1'b0};
        if (reached) begin
          tick_count_next = '0;
          st_next.phase   = PH_RED;
        end
      end
      PH_NIGHT: begin
        if (half_reached) begin
          tick_count_next      = '0;
          st_next.lamps.yellow = ~st.lamps.yellow;
        end
      end
      default: begin
        st_next.phase = PH_RED;
      end
    endcase
  end

endmodule

>>> hdl/traffic_light_sequencer.sv
// Traffic light sequencer: top level with handshake, registers and state.
// Depends on tls_pkg and tls_step.
//
// Each input transfer is one 1 ms tick carrying night_mode; each tick gives
// exactly one output transfer with the lamp levels and phase after the tick.
// Phases run red, red-yellow, green, green blinking, yellow and back to red,
// timed by one shared saturating tick counter of COUNT_WIDTH bits. Night mode
// is sampled only in red and leads to a yellow-blinking phase left only by
// reset. The next state is worked out by a single level of compare-and-increment
// logic, and the state registers double as the result register, so a tick is
// taken every cycle while the output side keeps up. in_ready is high when the
// result slot is empty or being drained this cycle. Configuration writes take
// effect at once and are expected only while no tick is in flight.
module traffic_light_sequencer #(
  parameter int COUNT_WIDTH = tls_pkg::COUNT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration write port
  input  logic                           cfg_write,
  input  logic [tls_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tls_pkg::CFG_DATA_W-1:0] cfg_data,
  // tick input
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           night_mode,
  // result output
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           lamp_red,
  output logic                           lamp_yellow,
  output logic                           lamp_green,
  output logic [tls_pkg::CODE_W-1:0]     phase_code
);
  import tls_pkg::*;

  cfg_t                   cfg;
  seq_state_t             st;
  seq_state_t             st_next;
  logic [COUNT_WIDTH-1:0] tick_count;
  logic [COUNT_WIDTH-1:0] tick_count_next;
  logic                   in_xfer;

  // A tick may enter when the result slot is free or is leaving now
  assign in_ready = ~out_valid | out_ready;
  assign in_xfer  = in_valid & in_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.red_ticks        <= RED_TICKS_RST;
      cfg.red_yellow_ticks <= RED_YELLOW_TICKS_RST;
      cfg.green_ticks      <= GREEN_TICKS_RST;
      cfg.blink_half_ticks <= BLINK_HALF_TICKS_RST;
      cfg.blink_toggles    <= BLINK_TOGGLES_RST;
      cfg.yellow_ticks     <= YELLOW_TICKS_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_RED_TICKS:        cfg.red_ticks        <= cfg_data[TIME_W-1:0];
        CFG_RED_YELLOW_TICKS: cfg.red_yellow_ticks <= cfg_data[TIME_W-1:0];
        CFG_GREEN_TICKS:      cfg.green_ticks      <= cfg_data[TIME_W-1:0];
        CFG_BLINK_HALF_TICKS: cfg.blink_half_ticks <= cfg_data[TIME_W-1:0];
        CFG_BLINK_TOGGLES:    cfg.blink_toggles    <= cfg_data[TOGGLE_W-1:0];
        CFG_YELLOW_TICKS:     cfg.yellow_ticks     <= cfg_data[TIME_W-1:0];
        default: ;  // unused indexes are ignored
      endcase
    end
  end

  tls_step #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_step (
    .cfg             (cfg),
    .st              (st),
    .tick_count      (tick_count),
    .night_mode      (night_mode),
    .st_next         (st_next),
    .tick_count_next (tick_count_next)
  );

  // Sequencer state; updated only on an input transfer, so it holds steady
  // as the pending result until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase        <= PH_RED;
      st.toggle_count <= '0;
      st.lamps        <= '0;
      tick_count      <= '0;
    end else if (in_xfer) begin
      st         <= st_next;
      tick_count <= tick_count_next;
    end
  end

  // Result slot occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign lamp_red    = st.lamps.red;
  assign lamp_yellow = st.lamps.yellow;
  assign lamp_green  = st.lamps.green;
  assign phase_code  = phase_code_f(st.phase);

endmodule
